FILE: src/pdlf_pkg.sv
// Shared constants for the pixel desaturate-and-lift filter.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package pdlf_pkg;

    localparam int          CHAN_W     = 8;
    localparam int          TDATA_W    = 4 * CHAN_W;
    localparam int          LIFT_W     = 17;
    localparam int          PIPE_DEPTH = 5;
    localparam logic [7:0]  CHAN_MAX   = 8'd255;
    localparam logic [16:0] LIFT_RESET = 17'd22282;

endpackage

`default_nettype wire

FILE: src/pixel_desaturate_lift_filter_top.sv
// Pixel desaturate-and-lift filter: five-stage pipeline over RGBA8 stream transfers.
// Depends on pdlf_pkg for channel widths, pipeline depth and the lift reset value.
//
// One pixel enters per clock when the output side takes every transfer, and its result
// leaves after passing in order through the five registered stages
// (luma and keep products, luma scaling multiply, desaturate and clamp, lift multiply,
// round and saturate). Each stage advances on its own, so a stall on the output fills
// bubbles before input ready drops. lift_amount is Q1.16 (0.34 after reset) and is
// written through the cfg channel, which is always ready; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module pixel_desaturate_lift_filter_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pdlf_pkg::LIFT_W-1:0]   cfg_data,    // lift_amount
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [pdlf_pkg::TDATA_W-1:0]  s_axis_tdata, // red_in, green_in, blue_in, alpha_in
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [pdlf_pkg::TDATA_W-1:0]       m_axis_tdata  // red_out, green_out, blue_out, alpha_out
);

    localparam int F      = FRAC_BITS;
    localparam int CW     = pdlf_pkg::CHAN_W;
    localparam int DEPTH  = pdlf_pkg::PIPE_DEPTH;
    localparam int LUM_W  = F + 9;
    localparam int KP_W   = F + 8;
    localparam int BP_W   = 2 * F + 9;
    localparam int N_W    = F + 10;
    localparam int NC_W   = F + 8;
    localparam int LF_W   = F + 2;
    localparam int LFX_W  = pdlf_pkg::LIFT_W + F + 1;
    localparam int LP_W   = 2 * F + 10;
    localparam int V_W    = F + 11;

    localparam longint unsigned ONE_L   = 64'(1) << F;
    localparam longint unsigned HALF_L  = 64'(1) << (F - 1);
    localparam longint unsigned CR_L    = ((64'(299) << F) + 64'(500)) / 64'(1000);
    localparam longint unsigned CG_L    = ((64'(587) << F) + 64'(500)) / 64'(1000);
    localparam longint unsigned CB_L    = ((64'(114) << F) + 64'(500)) / 64'(1000);
    localparam longint unsigned KEEP_L  = ((64'(12) << F) + 64'(50)) / 64'(100);
    localparam longint unsigned REST_L  = ONE_L - KEEP_L;
    localparam longint unsigned EXTRA_L = ((64'(6) << F) + 64'(50)) / 64'(100);

    localparam logic [LUM_W-1:0] C_R   = LUM_W'(CR_L);
    localparam logic [LUM_W-1:0] C_G   = LUM_W'(CG_L);
    localparam logic [LUM_W-1:0] C_B   = LUM_W'(CB_L);
    localparam logic [KP_W-1:0]  KEEP  = KP_W'(KEEP_L);
    localparam logic [BP_W-1:0]  REST  = BP_W'(REST_L);
    localparam logic [LF_W-1:0]  EXTRA = LF_W'(EXTRA_L);
    localparam logic [NC_W-1:0]  WHITE = NC_W'(pdlf_pkg::CHAN_MAX) << F;

    logic [pdlf_pkg::LIFT_W-1:0] lift_reg;
    logic [DEPTH-1:0]            valid_reg;
    logic [DEPTH-1:0]            en;

    logic [LUM_W-1:0] lum1_reg;
    logic [KP_W-1:0]  k1_reg  [3];
    logic [CW-1:0]    a1_reg;
    logic [BP_W-1:0]  bp2_reg;
    logic [KP_W-1:0]  k2_reg  [3];
    logic [CW-1:0]    a2_reg;
    logic [NC_W-1:0]  nc3_reg [3];
    logic [NC_W-1:0]  d3_reg  [3];
    logic [CW-1:0]    a3_reg;
    logic [NC_W-1:0]  nc4_reg [3];
    logic [LP_W-1:0]  lp4_reg [3];
    logic [CW-1:0]    a4_reg;
    logic [CW-1:0]    out5_reg [3];
    logic [CW-1:0]    a5_reg;

    logic [LUM_W-1:0] lum1_next;
    logic [KP_W-1:0]  k1_next  [3];
    logic [BP_W-1:0]  bp2_next;
    logic [NC_W-1:0]  nc3_next [3];
    logic [NC_W-1:0]  d3_next  [3];
    logic [LP_W-1:0]  lp4_next [3];
    logic [CW-1:0]    out5_next [3];

    logic [LFX_W-1:0] lf_wide;
    logic [LF_W-1:0]  lf;
    logic [LF_W-1:0]  lb;
    logic [CW-1:0]    ch_in [3];
    logic [N_W-1:0]   base3;
    logic [N_W-1:0]   n3    [3];
    logic [V_W-1:0]   v5    [3];
    logic [V_W-1:0]   rnd5  [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_reg <= pdlf_pkg::LIFT_RESET;
        end
        else if (cfg_valid)
        begin
            lift_reg <= cfg_data;
        end
    end

    // per-stage advance: a stage loads when it is empty or the next one loads
    always_comb
    begin
        en[DEPTH-1] = !valid_reg[DEPTH-1] || m_axis_tready;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        lf_wide = (LFX_W'(lift_reg) << F) + LFX_W'(32768);
        lf      = lf_wide[LFX_W-1:16];
        lb      = lf + EXTRA;

        ch_in[0] = s_axis_tdata[CW-1:0];
        ch_in[1] = s_axis_tdata[2*CW-1:CW];
        ch_in[2] = s_axis_tdata[3*CW-1:2*CW];

        lum1_next = LUM_W'(ch_in[0]) * C_R + LUM_W'(ch_in[1]) * C_G
                  + LUM_W'(ch_in[2]) * C_B;
        bp2_next  = BP_W'(lum1_reg) * REST;
        base3     = N_W'((bp2_reg + BP_W'(HALF_L)) >> F);

        for (int c = 0; c < 3; c++)
        begin
            k1_next[c]  = KP_W'(ch_in[c]) * KEEP;
            n3[c]       = base3 + N_W'(k2_reg[c]);
            nc3_next[c] = (n3[c] > N_W'(WHITE)) ? WHITE : NC_W'(n3[c]);
            d3_next[c]  = WHITE - nc3_next[c];
            lp4_next[c] = LP_W'(d3_reg[c]) * LP_W'((c == 2) ? lb : lf);
            v5[c]       = V_W'(nc4_reg[c]) + V_W'((lp4_reg[c] + LP_W'(HALF_L)) >> F);
            rnd5[c]     = (v5[c] + V_W'(HALF_L)) >> F;
            out5_next[c] = (rnd5[c] > V_W'(pdlf_pkg::CHAN_MAX)) ? pdlf_pkg::CHAN_MAX
                                                                : rnd5[c][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lum1_reg <= lum1_next;
            k1_reg   <= k1_next;
            a1_reg   <= s_axis_tdata[4*CW-1:3*CW];
        end
        if (en[1])
        begin
            bp2_reg <= bp2_next;
            k2_reg  <= k1_reg;
            a2_reg  <= a1_reg;
        end
        if (en[2])
        begin
            nc3_reg <= nc3_next;
            d3_reg  <= d3_next;
            a3_reg  <= a2_reg;
        end
        if (en[3])
        begin
            nc4_reg <= nc3_reg;
            lp4_reg <= lp4_next;
            a4_reg  <= a3_reg;
        end
        if (en[4])
        begin
            out5_reg <= out5_next;
            a5_reg   <= a4_reg;
        end
    end

    assign m_axis_tdata = {a5_reg, out5_reg[2], out5_reg[1], out5_reg[0]};

endmodule

`default_nettype wire

FILE: src/pdlf_checker.sv
// Port-level checker for the pixel desaturate-and-lift filter, with its bind.
// Depends on pdlf_pkg for data width and pipeline depth.
`timescale 1ns / 1ps
`default_nettype none

module pdlf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [pdlf_pkg::TDATA_W-1:0]  m_axis_tdata
);

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_xfer && !m_xfer)
        begin
            inflight_next = inflight_reg + 4'd1;
        end
        else if (m_xfer && !s_xfer)
        begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output stage is empty");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(pdlf_pkg::PIPE_DEPTH))
        else $error("more transfers in flight than pipeline stages");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 4'd0)
        else $error("output transfer offered with nothing in flight");

endmodule

bind pixel_desaturate_lift_filter_top pdlf_checker u_pdlf_checker (.*);

`default_nettype wire
